// ===== rtl/core/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int ValW   = 32;
  localparam int PosW   = 6;
  localparam int CountW = 6;

  // Request codes
  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_END   = 3'd1,
    REQ_INS_AFTER = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_END   = 3'd4,
    REQ_DEL_AFTER = 3'd5,
    REQ_LIST      = 3'd6,
    REQ_NOP       = 3'd7
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_POS = 2'd3
  } status_e;

  // What a cell loads on the next edge
  typedef enum logic [2:0] {
    CM_HOLD,
    CM_LOAD,
    CM_FROM_LEFT,
    CM_FROM_RIGHT,
    CM_FROM_HEAD
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       take;
  } cell_cmd_t;

endpackage

// ===== rtl/core/ple_cell.sv =====
// One storage cell of the list chain: holds a value, shifts with its neighbors.
module ple_cell (
  input  logic                                clk_i,
  input  ple_pkg::cell_cmd_t                  cmd_i,
  input  logic signed [ple_pkg::ValW-1:0]     load_val_i,
  input  logic signed [ple_pkg::ValW-1:0]     left_i,
  input  logic signed [ple_pkg::ValW-1:0]     right_i,
  input  logic signed [ple_pkg::ValW-1:0]     head_i,
  output logic signed [ple_pkg::ValW-1:0]     value_o,
  output logic signed [ple_pkg::ValW-1:0]     tap_o
);

  logic signed [ple_pkg::ValW-1:0] value_q, value_d;

  // Next value select
  always_comb begin
    unique case (cmd_i.mode)
      ple_pkg::CM_LOAD:       value_d = load_val_i;
      ple_pkg::CM_FROM_LEFT:  value_d = left_i;
      ple_pkg::CM_FROM_RIGHT: value_d = right_i;
      ple_pkg::CM_FROM_HEAD:  value_d = head_i;
      default:                value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // Gated read tap, OR-ed across the chain to pick the removed element
  assign tap_o   = cmd_i.take ? value_q : '0;

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Top level of the positional list engine: request decode, cell chain, result registers.
//
// Usage:
//   A request beat is taken at a rising edge where start_i is high and busy_o is low.
//   Inserts and deletes that succeed shift the cell chain in that same edge; every
//   insert, delete and no-op request gives one result in the next cycle, with done_o
//   high for one cycle and last_of_run_o set. busy_o stays low, so a new request can
//   follow every cycle. A list request on a non-empty list raises busy_o while the
//   chain rotates by one cell per cycle and cell 0 is streamed out, so results appear
//   one per cycle after the request, the last one marked. The chain is back in its
//   original order when busy_o drops. A list on an empty list gives a single result
//   with status "empty" in the next cycle. No new request is taken while a list
//   request streams its elements.
//   Results are shown for exactly one cycle; the receiver cannot stall them.
//   Reset clears the element count and the control state; cell contents are
//   never read beyond the count, so they need no reset.
module positional_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [2:0]                        req_type_i,
  input  logic signed [ple_pkg::ValW-1:0]   value_i,
  input  logic [ple_pkg::PosW-1:0]          position_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic signed [ple_pkg::ValW-1:0]   item_value_o,
  output logic                              item_valid_o,
  output logic                              last_of_run_o,
  output logic [ple_pkg::CountW-1:0]        element_count_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CmpW = (CW > ple_pkg::PosW) ? CW : ple_pkg::PosW;

  typedef enum logic {S_IDLE, S_LIST} state_e;

  state_e                          state_q;
  logic [CW-1:0]                   count_q, count_d;
  logic [IW-1:0]                   lidx_q;
  logic                            done_q, ivalid_q, last_q;
  ple_pkg::status_e                status_q, st;
  logic signed [ple_pkg::ValW-1:0] item_q, take_val;

  logic                            accept, empty, full, ins_ok, del_ok, rot;
  logic [IW-1:0]                   at, last_idx;
  logic [CmpW-1:0]                 pos_ext, cnt_ext;
  ple_pkg::req_e                   req;

  ple_pkg::cell_cmd_t              cmd   [CAPACITY];
  logic signed [ple_pkg::ValW-1:0] cval  [CAPACITY];
  logic signed [ple_pkg::ValW-1:0] ctap  [CAPACITY];

  assign busy_o   = (state_q == S_LIST);
  assign accept   = start_i && !busy_o;
  assign req      = ple_pkg::req_e'(req_type_i);
  assign empty    = (count_q == '0);
  assign full     = (count_q >= CW'(CAPACITY));
  assign pos_ext  = CmpW'(position_i);
  assign cnt_ext  = CmpW'(count_q);
  assign last_idx = IW'(count_q - CW'(1));
  assign rot      = busy_o;

  // Request decode: status, shift direction and target index
  always_comb begin
    st     = ple_pkg::ST_OK;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    at     = '0;
    if (accept) begin
      unique case (req)
        ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_END, ple_pkg::REQ_INS_AFTER: begin
          if (full) begin
            st = ple_pkg::ST_FULL;
          end else if (req == ple_pkg::REQ_INS_FRONT) begin
            ins_ok = 1'b1;
          end else if (req == ple_pkg::REQ_INS_END) begin
            ins_ok = 1'b1;
            at     = IW'(count_q);
          end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
            st = ple_pkg::ST_BAD_POS;
          end else begin
            ins_ok = 1'b1;
            at     = IW'(position_i);
          end
        end
        ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_END, ple_pkg::REQ_DEL_AFTER: begin
          if (empty) begin
            st = ple_pkg::ST_EMPTY;
          end else if (req == ple_pkg::REQ_DEL_FRONT) begin
            del_ok = 1'b1;
          end else if (req == ple_pkg::REQ_DEL_END) begin
            del_ok = 1'b1;
            at     = last_idx;
          end else if (pos_ext == '0 || pos_ext >= cnt_ext) begin
            st = ple_pkg::ST_BAD_POS;
          end else begin
            del_ok = 1'b1;
            at     = IW'(position_i);
          end
        end
        ple_pkg::REQ_LIST: begin
          if (empty) st = ple_pkg::ST_EMPTY;
        end
        default: st = ple_pkg::ST_OK;
      endcase
    end
  end

  // Per-cell command from its index against the target
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i].take = del_ok && (IW'(i) == at);
      cmd[i].mode = ple_pkg::CM_HOLD;
      if (ins_ok) begin
        if (IW'(i) == at)     cmd[i].mode = ple_pkg::CM_LOAD;
        else if (IW'(i) > at) cmd[i].mode = ple_pkg::CM_FROM_LEFT;
      end else if (del_ok) begin
        if (IW'(i) >= at && i < CAPACITY - 1) cmd[i].mode = ple_pkg::CM_FROM_RIGHT;
      end else if (rot) begin
        if (IW'(i) < last_idx)       cmd[i].mode = ple_pkg::CM_FROM_RIGHT;
        else if (IW'(i) == last_idx) cmd[i].mode = ple_pkg::CM_FROM_HEAD;
      end
    end
  end

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [ple_pkg::ValW-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cval[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cval[g+1];
    end
    ple_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd[g]),
      .load_val_i (value_i),
      .left_i     (left_v),
      .right_i    (right_v),
      .head_i     (cval[0]),
      .value_o    (cval[g]),
      .tap_o      (ctap[g])
    );
  end

  // Removed element: on a delete one cell taps, the rest give zero
  always_comb begin
    take_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      take_val = take_val | ctap[i];
    end
  end

  always_comb begin
    if (ins_ok)      count_d = count_q + CW'(1);
    else if (del_ok) count_d = count_q - CW'(1);
    else             count_d = count_q;
  end

  // State, count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      lidx_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ple_pkg::ST_OK;
      item_q   <= '0;
      ivalid_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (req == ple_pkg::REQ_LIST && !empty) begin
              state_q <= S_LIST;
              lidx_q  <= '0;
            end else begin
              done_q   <= 1'b1;
              status_q <= st;
              item_q   <= del_ok ? take_val : '0;
              ivalid_q <= del_ok;
              last_q   <= 1'b1;
              count_q  <= count_d;
            end
          end
        end
        S_LIST: begin
          done_q   <= 1'b1;
          status_q <= ple_pkg::ST_OK;
          item_q   <= cval[0];
          ivalid_q <= 1'b1;
          last_q   <= (lidx_q == last_idx);
          lidx_q   <= lidx_q + IW'(1);
          if (lidx_q == last_idx) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign item_value_o    = item_q;
  assign item_valid_o    = ivalid_q;
  assign last_of_run_o   = last_q;
  assign element_count_o = ple_pkg::CountW'(count_q);

  // Every list cycle yields a result beat on the next cycle
  a_list_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> done_o)
    else $error("list cycle without result beat");

  // A beat that is not the last of its run belongs to an ongoing list
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !last_of_run_o) |-> busy_o)
    else $error("unfinished run while idle");

  // Count never passes capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("count over capacity");

  // An element only comes with an ok status
  a_item_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && item_valid_o) |-> (status_o == ple_pkg::ST_OK))
    else $error("element with error status");

  // Count is frozen while the list streams
  a_count_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && $past(busy_o)) |-> $stable(count_q))
    else $error("count moved during list");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the positional list engine: directed and random requests.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ListCap   = 32;
  localparam int IdleLimit = 1000;

  // One expected result beat
  typedef struct {
    ple_pkg::status_e                  status;
    logic signed [ple_pkg::ValW-1:0]   val;
    logic                              valid;
    logic                              last;
    logic [ple_pkg::CountW-1:0]        cnt;
  } list_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              start_i;
  logic                              busy_o;
  logic [2:0]                        req_type_i;
  logic signed [ple_pkg::ValW-1:0]   value_i;
  logic [ple_pkg::PosW-1:0]          position_i;
  logic                              done_o;
  logic [1:0]                        status_o;
  logic signed [ple_pkg::ValW-1:0]   item_value_o;
  logic                              item_valid_o;
  logic                              last_of_run_o;
  logic [ple_pkg::CountW-1:0]        element_count_o;

  // Shadow copy of the list contents and the results still owed by the block
  logic signed [ple_pkg::ValW-1:0]   list_shadow[$];
  list_result_t                      pending_results[$];
  list_result_t                      head_result;

  int errors          = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int full_seen       = 0;
  int empty_seen      = 0;
  int bad_pos_seen    = 0;
  int burst_left      = 0;
  int idle_cycles     = 0;

  positional_list_engine #(
    .CAPACITY(ListCap)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .item_value_o   (item_value_o),
    .item_valid_o   (item_valid_o),
    .last_of_run_o  (last_of_run_o),
    .element_count_o(element_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predict the results of one accepted request and update the shadow list
  function automatic void apply_request(input ple_pkg::req_e req,
                                        input logic signed [ple_pkg::ValW-1:0] v,
                                        input logic [ple_pkg::PosW-1:0] pos);
    list_result_t r;
    int p;
    int len;
    p   = int'(pos);
    len = list_shadow.size();
    r   = '{status: ple_pkg::ST_OK, val: '0, valid: 1'b0, last: 1'b1, cnt: '0};
    case (req)
      ple_pkg::REQ_INS_FRONT, ple_pkg::REQ_INS_END, ple_pkg::REQ_INS_AFTER: begin
        if (len >= ListCap) r.status = ple_pkg::ST_FULL;
        else if (req == ple_pkg::REQ_INS_FRONT) list_shadow.push_front(v);
        else if (req == ple_pkg::REQ_INS_END) list_shadow.push_back(v);
        else if (p < 1 || p > len) r.status = ple_pkg::ST_BAD_POS;
        else list_shadow.insert(p, v);
      end
      ple_pkg::REQ_DEL_FRONT, ple_pkg::REQ_DEL_END, ple_pkg::REQ_DEL_AFTER: begin
        if (len == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else if (req == ple_pkg::REQ_DEL_FRONT) begin
          r.val   = list_shadow.pop_front();
          r.valid = 1'b1;
        end else if (req == ple_pkg::REQ_DEL_END) begin
          r.val   = list_shadow.pop_back();
          r.valid = 1'b1;
        end else if (p < 1 || p >= len) begin
          r.status = ple_pkg::ST_BAD_POS;
        end else begin
          r.val   = list_shadow[p];
          r.valid = 1'b1;
          list_shadow.delete(p);
        end
      end
      ple_pkg::REQ_LIST: begin
        // one beat per element, or a single empty beat
        if (len == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < len; i++) begin
            r = '{status: ple_pkg::ST_OK, val: list_shadow[i], valid: 1'b1,
                  last: (i == len - 1), cnt: ple_pkg::CountW'(len)};
            pending_results.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.cnt = ple_pkg::CountW'(list_shadow.size());
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      errors++;
    end
  endfunction

  // Result check and prediction, sampled mid-cycle so both sides are settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual status %0h value %0h",
                   $time, status_o, item_value_o);
          errors++;
        end else begin
          head_result = pending_results.pop_front();
          check_field("status", 32'(head_result.status), 32'(status_o));
          check_field("item_value", head_result.val, item_value_o);
          check_field("item_valid", 32'(head_result.valid), 32'(item_valid_o));
          check_field("last_of_run", 32'(head_result.last), 32'(last_of_run_o));
          check_field("element_count", 32'(head_result.cnt), 32'(element_count_o));
          results_checked++;
          case (head_result.status)
            ple_pkg::ST_FULL:    full_seen++;
            ple_pkg::ST_EMPTY:   empty_seen++;
            ple_pkg::ST_BAD_POS: bad_pos_seen++;
            default: ;
          endcase
        end
      end
      if (start_i && !busy_o) begin
        apply_request(ple_pkg::req_e'(req_type_i), value_i, position_i);
      end
    end
  end

  // Watchdog on cycles where no request beat is taken
  always @(negedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("%0t ns: no progress for %0d cycles", $time, IdleLimit);
      $display("[positional_list_engine] ERROR");
      $finish;
    end
  end

  // Send one request beat; the sender works in bursts with random gaps
  task automatic send_request(input ple_pkg::req_e req,
                              input logic signed [ple_pkg::ValW-1:0] val,
                              input logic [ple_pkg::PosW-1:0] pos);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    burst_left--;
    start_i    <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    position_i <= pos;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    items_sent++;
  endtask

  // Deletes, list, insert-after and no-op requests on an empty list
  task automatic test_empty_list();
    send_request(ple_pkg::REQ_DEL_FRONT, 32'sd0, 6'd0);
    send_request(ple_pkg::REQ_DEL_END, 32'sd5, 6'd1);
    send_request(ple_pkg::REQ_DEL_AFTER, 32'sd0, 6'd1);
    send_request(ple_pkg::REQ_LIST, 32'sd0, 6'd0);
    send_request(ple_pkg::REQ_INS_AFTER, 32'sd9, 6'd1);
    send_request(ple_pkg::REQ_NOP, $urandom(), 6'd63);
  endtask

  // Extreme values and positions, append through insert-after, bad positions
  task automatic test_value_extremes();
    send_request(ple_pkg::REQ_INS_FRONT, 32'sh7fffffff, 6'd0);
    send_request(ple_pkg::REQ_INS_END, 32'sh80000000, 6'd63);
    send_request(ple_pkg::REQ_INS_AFTER, 32'sd0, 6'd2);
    send_request(ple_pkg::REQ_INS_AFTER, -32'sd1, 6'd1);
    send_request(ple_pkg::REQ_INS_AFTER, 32'sd7, 6'd0);
    send_request(ple_pkg::REQ_INS_AFTER, 32'sd7, 6'd63);
    send_request(ple_pkg::REQ_LIST, 32'sd0, 6'd0);
    send_request(ple_pkg::REQ_DEL_AFTER, 32'sd0, 6'd4);
    send_request(ple_pkg::REQ_DEL_AFTER, 32'sd0, 6'd0);
    send_request(ple_pkg::REQ_DEL_AFTER, 32'sd0, 6'd2);
    send_request(ple_pkg::REQ_DEL_FRONT, 32'sd0, 6'd0);
    send_request(ple_pkg::REQ_NOP, -32'sd1, 6'd0);
    send_request(ple_pkg::REQ_LIST, 32'sd0, 6'd0);
    send_request(ple_pkg::REQ_DEL_END, 32'sd0, 6'd0);
    send_request(ple_pkg::REQ_LIST, 32'sd0, 6'd0);
  endtask

  // Random requests weighted toward inserts or deletes
  task automatic run_phase(input int n, input int ins_pct, input int del_pct);
    int r;
    int len;
    ple_pkg::req_e req;
    logic [ple_pkg::PosW-1:0] pos;
    for (int k = 0; k < n; k++) begin
      len = list_shadow.size();
      r   = $urandom_range(99);
      if (r < ins_pct) begin
        req = ple_pkg::req_e'($urandom_range(ple_pkg::REQ_INS_FRONT,
                                             ple_pkg::REQ_INS_AFTER));
      end else if (r < ins_pct + del_pct) begin
        req = ple_pkg::req_e'($urandom_range(ple_pkg::REQ_DEL_FRONT,
                                             ple_pkg::REQ_DEL_AFTER));
      end else if (r < ins_pct + del_pct + 6) begin
        req = ple_pkg::REQ_LIST;
      end else begin
        req = ple_pkg::REQ_NOP;
      end
      // mostly in-range positions, the rest anywhere in the field
      if (len > 0 && $urandom_range(3) != 0) pos = ple_pkg::PosW'($urandom_range(1, len));
      else pos = ple_pkg::PosW'($urandom_range(0, 63));
      send_request(req, $urandom(), pos);
    end
  endtask

  // Grow to full, drain to empty, then balanced traffic
  task automatic test_random_traffic();
    run_phase(70, 85, 10);
    run_phase(60, 8, 85);
    run_phase(70, 45, 45);
  endtask

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_type_i = ple_pkg::REQ_NOP;
    value_i    = '0;
    position_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_value_extremes();
    test_random_traffic();

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d result beats.", items_sent, results_checked);
    $display("Rejections seen: %0d full, %0d empty, %0d bad position.",
             full_seen, empty_seen, bad_pos_seen);
    if (errors == 0) begin
      $display("[positional_list_engine] OK");
    end else begin
      $display("[positional_list_engine] ERROR");
    end
    $finish;
  end

endmodule
